// ----- rtl/core/ppj_pkg.sv -----
// Shared types and codes for the proximity pair join block.
package ppj_pkg;

	localparam int COORD_W   = 20;
	localparam int CAV_ID_W  = 16;
	localparam int THRESH_W  = 40;
	localparam int SQ_W      = 41;
	localparam int SUM_W     = 42;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_APPEND,
		OP_QUERY
	} op_t;

	typedef enum logic {
		BS_IDLE,
		BS_SCAN
	} back_state_t;

	typedef struct packed {
		logic [1:0]                 func;
		logic signed [COORD_W-1:0]  pos_x;
		logic signed [COORD_W-1:0]  pos_y;
		logic signed [COORD_W-1:0]  pos_z;
		logic [CAV_ID_W-1:0]        cavity_id;
	} in_item_t;

	typedef struct packed {
		logic [CAV_ID_W-1:0] query_id;
		logic [CAV_ID_W-1:0] ref_id;
		logic                last;
	} out_item_t;

	typedef struct packed {
		op_t                        op;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
		logic [CAV_ID_W-1:0]        id;
	} cmd_t;

endpackage

// ----- rtl/core/ppj_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ppj_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/ppj_front.sv -----
// Front end: takes request items, decodes the function and queues commands.
module ppj_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  ppj_pkg::in_item_t req,
	output logic             cmd_valid,
	output ppj_pkg::cmd_t    cmd,
	input  logic             cmd_pop
);
	import ppj_pkg::*;

	localparam int DEPTH = 2;

	cmd_t        fifo_q [DEPTH];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        keep;
	logic        push;
	cmd_t        dec;

	// Unused function codes are taken and dropped here.
	always_comb begin
		keep   = 1'b1;
		dec.op = OP_CLEAR;
		case (req.func)
			FUNC_CLEAR:  dec.op = OP_CLEAR;
			FUNC_APPEND: dec.op = OP_APPEND;
			FUNC_QUERY:  dec.op = OP_QUERY;
			default:     keep   = 1'b0;
		endcase
		dec.x  = req.pos_x;
		dec.y  = req.pos_y;
		dec.z  = req.pos_z;
		dec.id = req.cavity_id;
	end

	assign req_stall = (fill_q == 2'(DEPTH));
	assign push      = req_valid && !req_stall && keep;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(cmd_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> cmd_valid)
		else $error("command popped from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= 2'(DEPTH))
		else $error("command queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with an empty queue");

endmodule

// ----- rtl/core/ppj_back.sv -----
// Back end: table maintenance, pipelined distance scan and pair output.
module ppj_back #(
	parameter int MAX_POINTS = 64,
	parameter int ID_WIDTH   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  ppj_pkg::cmd_t                  cmd,
	output logic                           cmd_pop,
	input  logic [ppj_pkg::THRESH_W-1:0]   thresh,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output ppj_pkg::out_item_t             rsp
);
	import ppj_pkg::*;

	localparam int IDW = (ID_WIDTH < CAV_ID_W) ? ID_WIDTH : CAV_ID_W;
	localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int RW  = 3 * COORD_W + IDW;

	back_state_t state_q, state_d;

	logic [CW-1:0]              ref_count_q;
	logic [CW-1:0]              scan_idx_q;
	logic [CW-1:0]              scan_end_q;
	logic signed [COORD_W-1:0]  qx_q, qy_q, qz_q;
	logic [IDW-1:0]             qid_q;

	logic                       v_s1;
	logic                       v_s2;
	logic [SQ_W-1:0]            sqx_s2, sqy_s2, sqz_s2;
	logic [IDW-1:0]             rid_s2;

	logic                       held_v_q;
	logic [IDW-1:0]             held_id_q;
	logic                       rsp_valid_q;
	out_item_t                  rsp_q;

	logic                       advance, issue, finish, ram_we, load_out;
	logic [RW-1:0]              ram_wdata, ram_rdata;
	logic signed [COORD_W-1:0]  rx, ry, rz;
	logic signed [COORD_W:0]    dx, dy, dz;
	logic signed [SUM_W-1:0]    px, py, pz;
	logic [SUM_W-1:0]           dist_sum;
	logic                       match;
	out_item_t                  out_d;

	assign ram_wdata = {cmd.id[IDW-1:0], cmd.z, cmd.y, cmd.x};

	ppj_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ref_count_q[AW-1:0]),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (scan_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (cmd_valid && cmd.op == OP_QUERY && ref_count_q != '0) begin
					state_d = BS_SCAN;
				end
			end
			BS_SCAN: begin
				if (finish && advance) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		advance = !rsp_valid_q || !rsp_stall;
		issue   = 1'b0;
		finish  = 1'b0;
		cmd_pop = 1'b0;
		ram_we  = 1'b0;
		case (state_q)
			BS_IDLE: begin
				cmd_pop = cmd_valid;
				ram_we  = cmd_valid && cmd.op == OP_APPEND &&
					ref_count_q < CW'(MAX_POINTS);
			end
			BS_SCAN: begin
				issue  = advance && (scan_idx_q != scan_end_q);
				finish = (scan_idx_q == scan_end_q) && !v_s1 && !v_s2;
			end
			default: ;
		endcase
	end

	// Distance datapath: squares from the read stage, sum and compare at s2.
	always_comb begin
		rx = ram_rdata[COORD_W-1:0];
		ry = ram_rdata[2*COORD_W-1:COORD_W];
		rz = ram_rdata[3*COORD_W-1:2*COORD_W];
		dx = (COORD_W+1)'(qx_q) - (COORD_W+1)'(rx);
		dy = (COORD_W+1)'(qy_q) - (COORD_W+1)'(ry);
		dz = (COORD_W+1)'(qz_q) - (COORD_W+1)'(rz);
		px = SUM_W'(dx) * SUM_W'(dx);
		py = SUM_W'(dy) * SUM_W'(dy);
		pz = SUM_W'(dz) * SUM_W'(dz);
		dist_sum = SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(sqz_s2);
		match    = v_s2 && (dist_sum < SUM_W'(thresh));
	end

	// A match is held back one step so the final pair of a query can be flagged.
	always_comb begin
		load_out = 1'b0;
		out_d    = rsp_q;
		if (advance) begin
			if (match && held_v_q) begin
				load_out       = 1'b1;
				out_d.query_id = CAV_ID_W'(qid_q);
				out_d.ref_id   = CAV_ID_W'(held_id_q);
				out_d.last     = 1'b0;
			end else if (finish && held_v_q) begin
				load_out       = 1'b1;
				out_d.query_id = CAV_ID_W'(qid_q);
				out_d.ref_id   = CAV_ID_W'(held_id_q);
				out_d.last     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == OP_QUERY) begin
			qx_q  <= cmd.x;
			qy_q  <= cmd.y;
			qz_q  <= cmd.z;
			qid_q <= cmd.id[IDW-1:0];
		end
		if (advance) begin
			sqx_s2 <= px[SQ_W-1:0];
			sqy_s2 <= py[SQ_W-1:0];
			sqz_s2 <= pz[SQ_W-1:0];
			rid_s2 <= ram_rdata[RW-1:3*COORD_W];
		end
		if (advance && match) begin
			held_id_q <= rid_s2;
		end
		if (load_out) begin
			rsp_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			ref_count_q <= '0;
			scan_idx_q  <= '0;
			scan_end_q  <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			held_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				case (cmd.op)
					OP_CLEAR: ref_count_q <= '0;
					OP_APPEND: begin
						if (ram_we) begin
							ref_count_q <= ref_count_q + CW'(1);
						end
					end
					OP_QUERY: begin
						scan_idx_q <= '0;
						scan_end_q <= ref_count_q;
					end
					default: ;
				endcase
			end
			if (issue) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end
			if (advance) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
				if (match) begin
					held_v_q <= 1'b1;
				end else if (finish) begin
					held_v_q <= 1'b0;
				end
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BS_IDLE) |-> !held_v_q && !v_s1 && !v_s2)
		else $error("scan left work behind on return to idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BS_SCAN) |-> (scan_idx_q <= scan_end_q))
		else $error("scan index ran past the table fill");
	assert property (@(posedge clk) disable iff (!arst_n)
		ref_count_q <= CW'(MAX_POINTS))
		else $error("table fill beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.last && !rsp_stall) |=> !held_v_q)
		else $error("pair held after the final pair of a query");

endmodule

// ----- rtl/core/proximity_pair_join.sv -----
// Top level of the fixed-radius proximity pair join between two 3D point sets.
//
// Usage. Request items arrive on req_valid / req_stall / req. A clear item
// empties the reference table, an append item stores one reference point
// (ignored once MAX_POINTS points are held), and a query item is compared in
// table order against every stored point. Each pair whose squared distance is
// strictly below the threshold register leaves as one item on rsp_valid /
// rsp_stall / rsp, carrying the query and reference ids; the final pair of a
// query has last set. A query with no match gives no item.
// Timing. Clear and append are done in the idle state of the back end. A query
// holds the back end while it scans the table: one entry is read per cycle
// while rsp_stall does not hold the output, then the read, s2 and hold stages
// drain. Each pair waits for the next match or the end of the scan, so that
// the final one can be marked. A two-entry command queue takes further items
// while a scan runs.
// Stall. When rsp_stall is high while rsp_valid is set, the whole scan
// pipeline freezes, and req_stall rises once the command queue is full.
// Configuration is written on cfg_valid / cfg_ready (always ready) and should
// only be written when idle. Reset clears the table fill, the queue and the
// output; the threshold returns to 2.0 squared.
module proximity_pair_join #(
	parameter int MAX_POINTS = 64,
	parameter int ID_WIDTH   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  ppj_pkg::in_item_t             req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output ppj_pkg::out_item_t            rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ppj_pkg::THRESH_W-1:0]  cfg_data
);
	import ppj_pkg::*;

	// 2.0 squared with sixteen fraction bits.
	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(262144);

	logic [THRESH_W-1:0] thresh_q;
	logic                cmd_valid;
	logic                cmd_pop;
	cmd_t                cmd;

	// The threshold register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	// Front end: decode and queue.
	ppj_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Back end: table, distance pipeline and output register.
	ppj_back #(
		.MAX_POINTS (MAX_POINTS),
		.ID_WIDTH   (ID_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.thresh    (thresh_q),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- test/ppj_pair_ledger_pkg.sv -----
// Scoreboard class that predicts and checks the pairs of the proximity pair join.
package ppj_pair_ledger_pkg;
	import ppj_pkg::*;

	localparam int TABLE_DEPTH = 64;

	class pair_ledger;
		logic [THRESH_W-1:0]        dist_limit;
		logic signed [COORD_W-1:0]  tab_x [TABLE_DEPTH];
		logic signed [COORD_W-1:0]  tab_y [TABLE_DEPTH];
		logic signed [COORD_W-1:0]  tab_z [TABLE_DEPTH];
		logic [CAV_ID_W-1:0]        tab_id [TABLE_DEPTH];
		int                         fill;
		out_item_t                  pairs_due [$];
		int                         pairs_predicted;
		int                         mismatches;

		function new();
			dist_limit = THRESH_W'(262144);
			fill = 0;
			pairs_predicted = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return pairs_due.size();
		endfunction

		// Square of one coordinate difference; exact, as the difference is 21 bits.
		function longint gap_sq(logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b);
			longint d;
			d = longint'(a) - longint'(b);
			return d * d;
		endfunction

		// Notes one accepted input item and queues the pairs it should produce.
		function void take_item(in_item_t it);
			longint    s;
			int        hits [$];
			out_item_t p;
			case (it.func)
			FUNC_CLEAR: begin
				fill = 0;
			end
			FUNC_APPEND: begin
				if (fill < TABLE_DEPTH) begin
					tab_x[fill]  = it.pos_x;
					tab_y[fill]  = it.pos_y;
					tab_z[fill]  = it.pos_z;
					tab_id[fill] = it.cavity_id;
					fill++;
				end
			end
			FUNC_QUERY: begin
				for (int i = 0; i < fill; i++) begin
					s = gap_sq(it.pos_x, tab_x[i]) + gap_sq(it.pos_y, tab_y[i])
						+ gap_sq(it.pos_z, tab_z[i]);
					if (s < longint'(dist_limit))
						hits.insert(hits.size(), i);
				end
				foreach (hits[k]) begin
					p.query_id = it.cavity_id;
					p.ref_id   = tab_id[hits[k]];
					p.last     = (k == hits.size() - 1);
					pairs_due.insert(pairs_due.size(), p);
				end
				pairs_predicted += hits.size();
			end
			default: begin
			end
			endcase
		endfunction

		task flag(string what);
			$display("pair mismatch: %s", what);
			mismatches++;
		endtask

		// Compares one accepted result item with the oldest pair due.
		task check_pair(out_item_t got);
			out_item_t want;
			if (pairs_due.size() == 0) begin
				flag($sformatf("pair %h/%h last %b arrived with none due",
					got.query_id, got.ref_id, got.last));
			end else begin
				want = pairs_due.pop_front();
				if (got.query_id !== want.query_id)
					flag($sformatf("query_id %h, wanted %h", got.query_id, want.query_id));
				if (got.ref_id !== want.ref_id)
					flag($sformatf("ref_id %h, wanted %h (query %h)",
						got.ref_id, want.ref_id, want.query_id));
				if (got.last !== want.last)
					flag($sformatf("last %b, wanted %b (query %h ref %h)",
						got.last, want.last, want.query_id, want.ref_id));
			end
		endtask
	endclass

endpackage

// ----- test/proximity_pair_join_test.sv -----
// Testbench top level for the proximity pair join: stimulus, idling and the final verdict.
module proximity_pair_join_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ppj_pkg::*;
	import ppj_pair_ledger_pkg::*;

	localparam int PERIOD = 10;
	// The spare function code, which the block must ignore.
	localparam logic [1:0] FUNC_SPARE = 2'd3;
	// A query on a full table holds the block while it scans every entry, and up to
	// two more commands may sit in the queue behind it, so this covers any work still
	// in flight once the last expected pair has come out.
	localparam int SETTLE_CYCLES = 4 * (TABLE_DEPTH + 8);
	// The slowest correct run is about a hundred and fifty items, a handful of them
	// queries on a full table giving up to 64 pairs each, every pair held up by the
	// receiver's stalls; this limit lies far beyond what such a run needs.
	localparam int CYCLE_LIMIT = 1000000;

	localparam logic [THRESH_W-1:0] LIMIT_MAX   = '1;
	localparam logic [THRESH_W-1:0] LIMIT_RESET = THRESH_W'(262144);

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	in_item_t             req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	out_item_t            rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [THRESH_W-1:0]  cfg_data = '0;

	// Chance, in percent, that the sender or the receiver idles in a given cycle.
	int send_pct = 0;
	int recv_pct = 0;
	int items_taken = 0;
	int cycle_count = 0;

	pair_ledger ledger;

	proximity_pair_join DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Receiver: every item taken at an edge is checked against the oldest pair due,
	// and the stall for the next cycle is drawn afresh. Both are sampled before the
	// edge's own updates land, so the order of processes does not matter.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			ledger.check_pair(rsp);
		rsp_stall <= ($urandom_range(0, 99) < recv_pct);
	end

	// Watchdog: if the run has not ended by the limit, something has hung.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("proximity_pair_join_test: errors");
		$finish;
	end

	function automatic in_item_t make_item(logic [1:0] f, int x, int y, int z, int id);
		in_item_t it;
		it.func      = f;
		it.pos_x     = x[COORD_W-1:0];
		it.pos_y     = y[COORD_W-1:0];
		it.pos_z     = z[COORD_W-1:0];
		it.cavity_id = id[CAV_ID_W-1:0];
		return it;
	endfunction

	// Any coordinate in the whole signed 20-bit range.
	function automatic int wild_coord();
		return int'($urandom_range(0, 1048575)) - 524288;
	endfunction

	// Mostly a point within about 1.5 units of the centre, so that pairs are found;
	// now and then a point anywhere at all.
	function automatic int scatter(int centre);
		if ($urandom_range(0, 9) < 8)
			return centre + int'($urandom_range(0, 800)) - 400;
		return wild_coord();
	endfunction

	function automatic int wild_id();
		return int'($urandom_range(0, 65535));
	endfunction

	// Offers one item, idling first at the sender's rate, and holds it steady until
	// the block takes it. Valid is left high on return, so that a following item can
	// go straight out; whoever comes next lowers it in the same step if need be.
	task automatic send_item(in_item_t it);
		while ($urandom_range(0, 99) < send_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do
			@(posedge clk);
		while (req_stall);
		ledger.take_item(it);
		items_taken++;
	endtask

	// Brings the block to rest: no item offered, no stall, every pair due has come
	// out, and any scan that finds nothing has had time to finish.
	task automatic settle_block();
		req_valid <= 1'b0;
		recv_pct = 0;
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the squared distance limit; the block must be at rest.
	task automatic write_limit(logic [THRESH_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		ledger.dist_limit = value;
	endtask

	// One well-formed sequence: perhaps a clear, a run of appends around one centre,
	// then queries around it, with the odd spare-code item and stray append mixed in.
	task automatic run_burst(int n_app, int n_qry, bit wipe);
		int cx;
		int cy;
		int cz;
		cx = int'($urandom_range(0, 1000000)) - 500000;
		cy = int'($urandom_range(0, 1000000)) - 500000;
		cz = int'($urandom_range(0, 1000000)) - 500000;
		if (wipe)
			send_item(make_item(FUNC_CLEAR, wild_coord(), wild_coord(), wild_coord(),
				wild_id()));
		for (int i = 0; i < n_app; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(make_item(FUNC_SPARE, wild_coord(), wild_coord(), wild_coord(),
					wild_id()));
			send_item(make_item(FUNC_APPEND, scatter(cx), scatter(cy), scatter(cz),
				wild_id()));
		end
		for (int i = 0; i < n_qry; i++) begin
			if ($urandom_range(0, 5) == 0)
				send_item(make_item(FUNC_APPEND, scatter(cx), scatter(cy), scatter(cz),
					wild_id()));
			send_item(make_item(FUNC_QUERY, scatter(cx), scatter(cy), scatter(cz),
				wild_id()));
		end
	endtask

	// Runs bursts until enough items have gone in and enough pairs are predicted,
	// with a ceiling on items in case the limit in force makes pairs scarce.
	task automatic random_phase(int min_items, int min_pairs);
		int items0;
		int pairs0;
		items0 = items_taken;
		pairs0 = ledger.pairs_predicted;
		while (((items_taken - items0) < min_items
				|| (ledger.pairs_predicted - pairs0) < min_pairs)
				&& (items_taken - items0) < 2 * min_items)
			run_burst($urandom_range(1, 12), $urandom_range(2, 6), $urandom_range(0, 3) != 0);
	endtask

	initial begin
		ledger = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, at the reset limit of 2.0 squared and the first idling rates.
		send_pct = 14;
		recv_pct = 55;
		// A query on an empty table gives nothing, and the spare code is ignored.
		send_item(make_item(FUNC_QUERY, 0, 0, 0, 16'hFFFF));
		send_item(make_item(FUNC_SPARE, -524288, 524287, 12345, 16'hFFFF));
		// The second point is just inside the limit, the third lies exactly on it.
		send_item(make_item(FUNC_APPEND, 0, 0, 0, 16'h0001));
		send_item(make_item(FUNC_APPEND, 511, 0, 0, 16'h0002));
		send_item(make_item(FUNC_APPEND, 0, 0, 512, 16'h0003));
		send_item(make_item(FUNC_APPEND, 524287, -524288, 524287, 16'hFFFF));
		send_item(make_item(FUNC_APPEND, -524288, 524287, -524288, 16'h0000));
		send_item(make_item(FUNC_QUERY, 0, 0, 0, 16'hABCD));
		send_item(make_item(FUNC_QUERY, 524287, -524288, 524287, 16'h5555));
		send_item(make_item(FUNC_QUERY, -524288, 524287, -524288, 16'hAAAA));
		send_item(make_item(FUNC_QUERY, 0, -300, -400, 16'h1111));
		// After a clear the old entries must no longer match.
		send_item(make_item(FUNC_CLEAR, 0, 0, 0, 16'h0000));
		send_item(make_item(FUNC_QUERY, 0, 0, 0, 16'h2222));
		send_item(make_item(FUNC_APPEND, -1, -1, -1, 16'h8000));
		send_item(make_item(FUNC_APPEND, 1, 1, 1, 16'h7FFF));
		send_item(make_item(FUNC_QUERY, 0, 0, 0, 16'h1234));
		send_item(make_item(FUNC_SPARE, 524287, -524288, -1, 16'h0000));

		// At the largest limit, corner-to-corner distances come close to the top of the
		// 42-bit sum; the longest diagonal still lies beyond the limit.
		settle_block();
		write_limit(LIMIT_MAX);
		recv_pct = 55;
		send_item(make_item(FUNC_QUERY, 524287, 524287, 524287, 16'h0F0F));
		send_item(make_item(FUNC_APPEND, 524287, 524287, 524287, 16'hFFFF));
		send_item(make_item(FUNC_QUERY, -524288, -524288, -524288, 16'hF0F0));
		send_item(make_item(FUNC_QUERY, 0, 0, 0, 16'h0000));

		// First random phase: the sender idles a little, the receiver a lot.
		settle_block();
		write_limit(LIMIT_RESET);
		send_pct = 14;
		recv_pct = 55;
		random_phase(20, 8);

		// Second random phase: the other way round, at a random limit.
		settle_block();
		write_limit(THRESH_W'($urandom_range(100000, 1500000)));
		send_pct = 55;
		recv_pct = 14;
		random_phase(20, 8);

		// Last phase, without idling. With a zero limit nothing can match.
		settle_block();
		write_limit('0);
		send_pct = 0;
		recv_pct = 0;
		run_burst(4, 4, 1'b0);
		// Then the table is filled past capacity, so the last appends are dropped,
		// and queried while full.
		settle_block();
		write_limit(THRESH_W'(1500000));
		run_burst(TABLE_DEPTH + 3, 4, 1'b1);

		settle_block();
		if (ledger.mismatches == 0 && ledger.pending() == 0) begin
			$display("proximity_pair_join_test: clean");
		end else begin
			$display("proximity_pair_join_test: errors");
		end
		$finish;
	end

endmodule
